### design/assert_macros.svh
// Assertion macros shared by the blur core modules.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define RGBB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RGBB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RGBB_ASSERT(label, clk, rst, prop, msg)
`define RGBB_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RGBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### design/rgbb_pkg.sv
// Shared types and constants of the RGB 5x5 blur core.
// No dependencies; imported by every module of the core.
`default_nettype none

package rgbb_pkg;

   localparam int KERNEL_SIZE = 5;
   localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
   localparam int CENTER_TAP  = KERNEL_TAPS / 2;
   localparam int LINE_ROWS   = KERNEL_SIZE - 1;

   localparam int CHAN_BITS   = 8;
   localparam int CHANNELS    = 3;
   localparam int PIXEL_BITS  = CHAN_BITS * CHANNELS;
   localparam int WIDTH_BITS  = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int WARM_BITS   = WIDTH_BITS + 2;
   localparam int SUM_BITS    = 13;
   localparam int RECIP_BITS  = 14;
   localparam int RECIP_SHIFT = 18;

   localparam int unsigned MAX_HEIGHT = 4096;

   localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 12'd640;
   localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 13'd480;

   // floor(x / 27) == (x * 9710) >> 18 for every x below 10082
   localparam logic [RECIP_BITS-1:0] RECIP_KERNEL_SUM = 14'd9710;
   localparam logic [CHAN_BITS-1:0]  CHAN_MAX         = 8'hFF;

   // diamond kernel, raster order, weights sum to 27
   localparam logic [2:0] BLUR_WEIGHT [KERNEL_TAPS] = '{
      3'd0, 3'd0, 3'd1, 3'd0, 3'd0,
      3'd0, 3'd1, 3'd3, 3'd1, 3'd0,
      3'd1, 3'd3, 3'd7, 3'd3, 3'd1,
      3'd0, 3'd1, 3'd3, 3'd1, 3'd0,
      3'd0, 3'd0, 3'd1, 3'd0, 3'd0
   };

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef logic [KERNEL_TAPS-1:0][CHAN_BITS-1:0] chan_window_type;
   typedef logic [LINE_ROWS-1:0][PIXEL_BITS-1:0]  column_word_type;

   typedef struct packed {
      logic emit;
      logic interior;
      logic last;
   } item_ctrl_type;

endpackage

`default_nettype wire

### design/rgbb_line_store.sv
// Line store of the blur core: one word per column holding the last four rows.
// Depends on rgbb_pkg for the column word type.
`default_nettype none

module rgbb_line_store #(
   parameter int  DEPTH     = 2048,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire                        clock,
   input  wire                        rd_en,
   input  wire  [ADDR_BITS-1:0]       rd_addr,
   input  wire                        wr_en,
   input  wire  [ADDR_BITS-1:0]       wr_addr,
   input  rgbb_pkg::column_word_type  wr_data,
   output rgbb_pkg::column_word_type  rd_data
);
   import rgbb_pkg::*;

   column_word_type mem [DEPTH];
   column_word_type rd_word_ff;
   column_word_type last_wr_ff;
   logic            fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
         last_wr_ff   <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
         // read and write of one column at the same edge: take the new word
         fwd_ff     <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? last_wr_ff : rd_word_ff;

endmodule

`default_nettype wire

### design/rgbb_lane.sv
// One color channel of the blur: weighted 5x5 sum, divide by 27, clamp.
// Depends on rgbb_pkg for the kernel weights and window type.
`default_nettype none

module rgbb_lane (
   input  wire                                clock,
   input  wire                                enable,
   input  rgbb_pkg::chan_window_type          window,
   output logic [rgbb_pkg::CHAN_BITS-1:0]     blur,
   output logic [rgbb_pkg::CHAN_BITS-1:0]     center
);
   import rgbb_pkg::*;

   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam int SCALED_BITS = PROD_BITS - RECIP_SHIFT;

   logic [KERNEL_SIZE-1:0][SUM_BITS-1:0] row_sum_in;
   logic [KERNEL_SIZE-1:0][SUM_BITS-1:0] row_sum_ff;
   logic [SUM_BITS-1:0]    total_in;
   logic [SUM_BITS-1:0]    total_ff;
   logic [PROD_BITS-1:0]   product;
   logic [SCALED_BITS-1:0] scaled;
   logic [CHAN_BITS-1:0]   quot_in;
   logic [CHAN_BITS-1:0]   quot_ff;
   logic [CHAN_BITS-1:0]   center_s2_ff;
   logic [CHAN_BITS-1:0]   center_s3_ff;
   logic [CHAN_BITS-1:0]   center_s4_ff;

   // per kernel row partial sums
   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         row_sum_in[r] = '0;
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            row_sum_in[r] = row_sum_in[r]
               + SUM_BITS'(window[r*KERNEL_SIZE+c]) * SUM_BITS'(BLUR_WEIGHT[r*KERNEL_SIZE+c]);
         end
      end
   end

   always_comb begin
      total_in = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         total_in = total_in + row_sum_ff[r];
      end
   end

   assign product = PROD_BITS'(total_ff) * PROD_BITS'(RECIP_KERNEL_SUM);
   assign scaled  = product[PROD_BITS-1:RECIP_SHIFT];
   assign quot_in = (scaled > SCALED_BITS'(CHAN_MAX)) ? CHAN_MAX : scaled[CHAN_BITS-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         row_sum_ff   <= row_sum_in;
         center_s2_ff <= window[CENTER_TAP];
         total_ff     <= total_in;
         center_s3_ff <= center_s2_ff;
         quot_ff      <= quot_in;
         center_s4_ff <= center_s3_ff;
      end
   end

   assign blur   = quot_ff;
   assign center = center_s4_ff;

endmodule

`default_nettype wire

### design/rgbb_merge.sv
// Merge stage: picks blurred or passed-through pixel and holds the result
// channel in an output register plus skid register. Depends on rgbb_pkg.
`default_nettype none

`include "assert_macros.svh"

module rgbb_merge (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   input  rgbb_pkg::item_ctrl_type           in_ctrl,
   input  wire  [rgbb_pkg::PIXEL_BITS-1:0]   blur_pixel,
   input  wire  [rgbb_pkg::PIXEL_BITS-1:0]   center_pixel,
   output logic                              in_ready,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [rgbb_pkg::PIXEL_BITS-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import rgbb_pkg::*;

   logic [PIXEL_BITS-1:0] pick;
   logic                  push;
   logic                  pop;

   logic                  out_valid_ff, out_valid_in;
   logic [PIXEL_BITS-1:0] out_data_ff, out_data_in;
   logic                  out_last_ff, out_last_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [PIXEL_BITS-1:0] skid_data_ff, skid_data_in;
   logic                  skid_last_ff, skid_last_in;

   assign pick     = in_ctrl.interior ? blur_pixel : center_pixel;
   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ctrl.emit && in_ready;
   assign pop      = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = pick;
            out_last_in  = in_ctrl.last;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = pick;
            skid_last_in  = in_ctrl.last;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      skid_data_ff <= skid_data_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   `RGBB_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid holds a result while the output register is empty")
   `RGBB_ASSERT_IMPL(a_skid_fill_on_stall, clock, reset, $rose(skid_valid_ff), $past(out_valid_ff && !rsp_tready), "skid filled without a stalled output")

endmodule

`default_nettype wire

### design/rgb_blur_5x5_convolution_core.sv
// Top level of the RGB 5x5 diamond blur core: frame counters, window, CSRs.
// Depends on rgbb_pkg, rgbb_line_store, rgbb_lane, rgbb_merge, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// RGB888 pixels enter in raster order on the req_ stream, one transfer per
// clock, and leave blurred on the rsp_ stream in the same order, one result per
// pixel. Interior pixels get floor(weighted 5x5 diamond sum / 27) per channel;
// pixels within two of an edge, and whole images smaller than 5x5, pass
// through. A result is due once the pixel two rows and two columns later has
// been taken, so after the last pixel of a frame send drain transfers
// (req_tuser = 1) until the result with rsp_tlast arrives; drains at other
// times are swallowed. A pixel sent after a frame's last pixel starts a new
// frame and drops what was not drained. Writing either CSR (image_width at
// byte 0, image_height at byte 4) restarts the frame; write only while idle.
// Throughput is one transfer per clock while the skid register is empty,
// limited by the single read and single write port of the line store
// (MAX_WIDTH words of four pixels). From the transfer that completes a window,
// its result passes line store read, window shift, row sums, total, divide and
// output register. With rsp_tready low the block keeps taking transfers until
// its skid register fills. No clearing pass is needed after reset.
module rgb_blur_5x5_convolution_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // input pixel stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
   input  wire         req_tuser,   // kind [0]: 0 pixel, 1 drain
   // result stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
   output logic        rsp_tlast    // frame_last
);
   import rgbb_pkg::*;

   localparam int ADDR_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PIPE_STAGES = 5;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  w;
      logic [WIDTH_BITS-1:0]  wm1;
      logic [WIDTH_BITS-1:0]  wm2;
      logic [HEIGHT_BITS-1:0] h;
      logic [HEIGHT_BITS-1:0] hm1;
      logic [HEIGHT_BITS-1:0] hm2;
      logic [WARM_BITS-1:0]   warm;
      logic                   big;
   } geometry_type;

   // clamp the raw registers and precompute the compare limits
   function automatic geometry_type derive_geometry(input logic [WIDTH_BITS-1:0] wr,
                                                    input logic [HEIGHT_BITS-1:0] hr);
      geometry_type           g;
      logic [WIDTH_BITS-1:0]  w;
      logic [HEIGHT_BITS-1:0] h;
      if (wr == '0) begin
         w = WIDTH_BITS'(1);
      end else if (32'(wr) > MAX_WIDTH) begin
         w = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w = wr;
      end
      if (hr == '0) begin
         h = HEIGHT_BITS'(1);
      end else if (32'(hr) > MAX_HEIGHT) begin
         h = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         h = hr;
      end
      g.w    = w;
      g.wm1  = w - WIDTH_BITS'(1);
      g.wm2  = w - WIDTH_BITS'(2);
      g.h    = h;
      g.hm1  = h - HEIGHT_BITS'(1);
      g.hm2  = h - HEIGHT_BITS'(2);
      g.warm = {1'b0, w, 1'b0} + WARM_BITS'(2);
      g.big  = (w >= WIDTH_BITS'(KERNEL_SIZE)) && (h >= HEIGHT_BITS'(KERNEL_SIZE));
      return g;
   endfunction

   // ---------------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------------
   logic [WIDTH_BITS-1:0]  width_reg_ff;
   logic [HEIGHT_BITS-1:0] height_reg_ff;
   geometry_type           geo_ff;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_IMAGE_HEIGHT) ? 32'(height_reg_ff)
                                                          : 32'(width_reg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= RESET_WIDTH;
         height_reg_ff <= RESET_HEIGHT;
         geo_ff        <= derive_geometry(RESET_WIDTH, RESET_HEIGHT);
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_IMAGE_WIDTH: begin
               width_reg_ff <= csr_pwdata[WIDTH_BITS-1:0];
               geo_ff       <= derive_geometry(csr_pwdata[WIDTH_BITS-1:0], height_reg_ff);
            end
            REG_IMAGE_HEIGHT: begin
               height_reg_ff <= csr_pwdata[HEIGHT_BITS-1:0];
               geo_ff        <= derive_geometry(width_reg_ff, csr_pwdata[HEIGHT_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Frame position counters (input side and result side)
   // ---------------------------------------------------------------------
   logic                   pipe_ready;
   logic                   accept;
   logic                   is_pixel;
   logic                   restart_a;
   logic                   step_a;
   logic                   emit_a;
   logic                   interior_a;
   logic                   last_a;

   logic [WIDTH_BITS-1:0]  col_ff, col_in, col_a;
   logic [HEIGHT_BITS-1:0] row_ff, row_in, row_a;
   logic [WARM_BITS-1:0]   warm_ff, warm_in, warm_a;
   logic [WIDTH_BITS-1:0]  ocol_ff, ocol_in, ocol_a;
   logic [HEIGHT_BITS-1:0] orow_ff, orow_in, orow_a;
   logic                   done_ff, done_in, done_a;

   assign req_tready = pipe_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_pixel   = (req_tuser == KIND_PIXEL);

   // a pixel after the frame's last pixel opens a new frame
   assign restart_a = is_pixel && done_ff;
   assign col_a     = restart_a ? '0 : col_ff;
   assign row_a     = restart_a ? '0 : row_ff;
   assign warm_a    = restart_a ? '0 : warm_ff;
   assign ocol_a    = restart_a ? '0 : ocol_ff;
   assign orow_a    = restart_a ? '0 : orow_ff;
   assign done_a    = restart_a ? 1'b0 : done_ff;

   // drains count only once every pixel of the frame is in
   assign step_a     = (req_tuser == KIND_DRAIN) ? done_ff : 1'b1;
   assign emit_a     = (warm_a == geo_ff.warm);
   assign interior_a = geo_ff.big
                    && (orow_a >= HEIGHT_BITS'(2)) && (orow_a < geo_ff.hm2)
                    && (ocol_a >= WIDTH_BITS'(2)) && (ocol_a < geo_ff.wm2);
   assign last_a     = (orow_a == geo_ff.hm1) && (ocol_a == geo_ff.wm1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      warm_in = warm_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      done_in = done_ff;
      if (csr_write) begin
         col_in  = '0;
         row_in  = '0;
         warm_in = '0;
         ocol_in = '0;
         orow_in = '0;
         done_in = 1'b0;
      end else if (accept && step_a) begin
         if (col_a == geo_ff.wm1) begin
            col_in = '0;
            row_in = row_a + HEIGHT_BITS'(1);
         end else begin
            col_in = col_a + WIDTH_BITS'(1);
            row_in = row_a;
         end
         warm_in = emit_a ? warm_a : warm_a + WARM_BITS'(1);
         done_in = done_a || (is_pixel && (row_a == geo_ff.hm1) && (col_a == geo_ff.wm1));
         ocol_in = ocol_a;
         orow_in = orow_a;
         if (emit_a) begin
            if (ocol_a == geo_ff.wm1) begin
               ocol_in = '0;
               orow_in = orow_a + HEIGHT_BITS'(1);
            end else begin
               ocol_in = ocol_a + WIDTH_BITS'(1);
            end
            // last result of the frame: clear everything for the next one
            if (last_a) begin
               col_in  = '0;
               row_in  = '0;
               warm_in = '0;
               ocol_in = '0;
               orow_in = '0;
               done_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         warm_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         warm_ff <= warm_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         done_ff <= done_in;
      end
   end

   // ---------------------------------------------------------------------
   // Control pipeline: stage 0 reads the line store, stage 1 holds the
   // shifted window, stages 2..4 follow the lanes.
   // ---------------------------------------------------------------------
   logic [PIPE_STAGES-1:0] stage_valid_ff;
   item_ctrl_type          stage_ctrl_ff [PIPE_STAGES];
   item_ctrl_type          ctrl_a;

   assign ctrl_a.emit     = emit_a;
   assign ctrl_a.interior = interior_a;
   assign ctrl_a.last     = last_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (pipe_ready) begin
         stage_valid_ff <= {stage_valid_ff[PIPE_STAGES-2:0], accept && step_a};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_ready) begin
         stage_ctrl_ff[0] <= ctrl_a;
         for (int s = 1; s < PIPE_STAGES; s++) begin
            stage_ctrl_ff[s] <= stage_ctrl_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Line store and 5x5 window
   // ---------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] s0_pix_ff;
   logic [ADDR_BITS-1:0]  s0_addr_ff;
   logic                  line_wr;
   column_word_type       line_rd_word;
   column_word_type       line_wr_word;

   logic [KERNEL_SIZE-1:0][PIXEL_BITS-1:0]                  new_col;
   logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIXEL_BITS-1:0] win_ff, win_in;

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_pix_ff  <= req_tdata;
         s0_addr_ff <= ADDR_BITS'(col_a);
      end
   end

   assign line_wr = stage_valid_ff[0] && pipe_ready;

   rgbb_line_store #(
      .DEPTH   (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept && step_a),
      .rd_addr (ADDR_BITS'(col_a)),
      .wr_en   (line_wr),
      .wr_addr (s0_addr_ff),
      .wr_data (line_wr_word),
      .rd_data (line_rd_word)
   );

   // column word holds rows r-4 .. r-1 of this column; push the new pixel in
   always_comb begin
      for (int i = 0; i < LINE_ROWS; i++) begin
         new_col[i] = line_rd_word[i];
      end
      new_col[KERNEL_SIZE-1] = s0_pix_ff;
      for (int i = 0; i < LINE_ROWS - 1; i++) begin
         line_wr_word[i] = line_rd_word[i+1];
      end
      line_wr_word[LINE_ROWS-1] = s0_pix_ff;
   end

   // shift every window row left and bring in the new column on the right
   always_comb begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
            win_in[i][j] = win_ff[i][j+1];
         end
         win_in[i][KERNEL_SIZE-1] = new_col[i];
      end
   end

   always_ff @(posedge clock) begin
      if (line_wr) begin
         win_ff <= win_in;
      end
   end

   // ---------------------------------------------------------------------
   // Channel lanes and merge
   // ---------------------------------------------------------------------
   chan_window_type       chan_win [CHANNELS];
   logic [PIXEL_BITS-1:0] blur_pixel;
   logic [PIXEL_BITS-1:0] center_pixel;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         for (int t = 0; t < KERNEL_TAPS; t++) begin
            chan_win[c][t] = win_ff[t / KERNEL_SIZE][t % KERNEL_SIZE][c*CHAN_BITS +: CHAN_BITS];
         end
      end
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      rgbb_lane u_lane (
         .clock  (clock),
         .enable (pipe_ready),
         .window (chan_win[c]),
         .blur   (blur_pixel[c*CHAN_BITS +: CHAN_BITS]),
         .center (center_pixel[c*CHAN_BITS +: CHAN_BITS])
      );
   end

   rgbb_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stage_valid_ff[PIPE_STAGES-1]),
      .in_ctrl      (stage_ctrl_ff[PIPE_STAGES-1]),
      .blur_pixel   (blur_pixel),
      .center_pixel (center_pixel),
      .in_ready     (pipe_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   `RGBB_ASSERT(a_col_in_range, clock, reset, col_ff < geo_ff.w, "input column beyond image width")
   `RGBB_ASSERT(a_ocol_in_range, clock, reset, ocol_ff < geo_ff.w, "result column beyond image width")
   `RGBB_ASSERT_NEXT(a_last_restarts, clock, reset, accept && step_a && emit_a && last_a, (col_ff == '0) && (warm_ff == '0) && !done_ff, "frame counters not cleared after last result")

endmodule

`default_nettype wire
